FILE: rtl/skt_pkg.sv
// Shared types and codes for the sorted key table.
package skt_pkg;

    // Operation codes carried in the request mode bit
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } skt_status_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY
    } skt_state_t;

    // One request transfer
    typedef struct packed {
        logic               mode;
        logic signed [31:0] part_key;
        logic signed [31:0] quantity;
    } skt_in_t;

    // One result transfer
    typedef struct packed {
        skt_status_t        status;
        logic signed [31:0] found_quantity;
    } skt_out_t;

    // Entry contents handed from one cell to the next
    typedef struct packed {
        logic               valid;
        logic               lt;
        logic signed [31:0] key;
        logic signed [31:0] qty;
    } skt_link_t;

    // Match accumulator rippling down the chain
    typedef struct packed {
        logic               hit;
        logic signed [31:0] qty;
    } skt_res_t;

endpackage

FILE: rtl/skt_cell.sv
// One entry cell of the sorted chain: compare, shift on insert, pass match.
module skt_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic signed [31:0] cmd_key,
    input  logic signed [31:0] cmd_qty,
    input  logic              insert_en,
    input  skt_pkg::skt_link_t prev_link,
    input  skt_pkg::skt_res_t  prev_res,
    output skt_pkg::skt_link_t link,
    output skt_pkg::skt_res_t  res
);

    logic               valid_reg;
    logic               valid_next;
    logic signed [31:0] key_reg;
    logic signed [31:0] key_next;
    logic signed [31:0] qty_reg;
    logic signed [31:0] qty_next;
    skt_pkg::skt_res_t  res_reg;
    skt_pkg::skt_res_t  res_next;
    logic               lt;
    logic               hit;

    // Compare the stored key against the broadcast key
    assign lt  = valid_reg && (key_reg < cmd_key);
    assign hit = valid_reg && (key_reg == cmd_key);

    // Keep, take the new entry, or take the neighbor's entry
    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        qty_next   = qty_reg;
        if (insert_en)
        begin
            valid_next = valid_reg | prev_link.valid;
            priority if (lt)
            begin
                key_next = key_reg;
                qty_next = qty_reg;
            end
            else if (prev_link.lt)
            begin
                key_next = cmd_key;
                qty_next = cmd_qty;
            end
            else
            begin
                key_next = prev_link.key;
                qty_next = prev_link.qty;
            end
        end
    end

    // Accumulate the match from upstream cells
    always_comb
    begin
        res_next.hit = prev_res.hit | hit;
        res_next.qty = prev_res.qty | (hit ? qty_reg : 32'sd0);
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold entry payload and match accumulator
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        qty_reg <= qty_next;
        res_reg <= res_next;
    end

    assign link.valid = valid_reg;
    assign link.lt    = lt;
    assign link.key   = key_reg;
    assign link.qty   = qty_reg;
    assign res        = res_reg;

endmodule

FILE: rtl/sorted_key_table_core.sv
// Top level of the sorted key table: controller and chain of entry cells.
//
//   channel  | handshake              | payload
//   ---------+------------------------+--------------------------------------
//   request  | start, busy            | request (mode, part_key, quantity)
//   result   | result_valid (strobe)  | result (status, found_quantity)
//
// An operation keeps busy high through the scan and apply states. During the
// scan the match ripples one cell per cycle down the chain; the apply state
// decides the status and shifts the cells on an insert. The result strobe comes
// in the cycle busy drops, and a new start is taken in that same cycle.
// Reset empties the table at once; the receiver cannot stall results.
module sorted_key_table_core #(
    parameter int CAPACITY = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  skt_pkg::skt_in_t request,
    output logic             result_valid,
    output skt_pkg::skt_out_t result
);

    localparam int CW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    skt_pkg::skt_state_t state_reg;
    skt_pkg::skt_state_t state_next;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    skt_pkg::skt_in_t    cmd_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    skt_pkg::skt_out_t   out_reg;
    skt_pkg::skt_out_t   out_next;
    logic                insert_en;
    logic                accept;
    logic                full;
    skt_pkg::skt_res_t   tail_res;

    skt_pkg::skt_link_t  link [CAPACITY+1];
    skt_pkg::skt_res_t   res  [CAPACITY+1];

    assign accept = start && (state_reg == skt_pkg::S_IDLE);

    // Head of the chain: new entry goes to cell 0 unless a smaller key is there
    assign link[0].valid = 1'b1;
    assign link[0].lt    = 1'b1;
    assign link[0].key   = 32'sd0;
    assign link[0].qty   = 32'sd0;
    assign res[0].hit    = 1'b0;
    assign res[0].qty    = 32'sd0;

    // Build the row of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        skt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd_key   (cmd_reg.part_key),
            .cmd_qty   (cmd_reg.quantity),
            .insert_en (insert_en),
            .prev_link (link[i]),
            .prev_res  (res[i]),
            .link      (link[i+1]),
            .res       (res[i+1])
        );
    end

    assign full     = link[CAPACITY].valid;
    assign tail_res = res[CAPACITY];

    // Next state, status decision and insert enable
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = 1'b0;
        out_next       = out_reg;
        insert_en      = 1'b0;
        unique case (state_reg)
            skt_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = skt_pkg::S_SCAN;
                    count_next = '0;
                end
            end
            skt_pkg::S_SCAN:
            begin
                count_next = count_reg + CW'(1);
                if (count_reg == CW'(CAPACITY - 1))
                begin
                    state_next = skt_pkg::S_APPLY;
                end
            end
            skt_pkg::S_APPLY:
            begin
                state_next              = skt_pkg::S_IDLE;
                out_valid_next          = 1'b1;
                out_next.found_quantity = 32'sd0;
                if (cmd_reg.mode == skt_pkg::MODE_INSERT)
                begin
                    priority if (full)
                    begin
                        out_next.status = skt_pkg::ST_FULL;
                    end
                    else if (tail_res.hit)
                    begin
                        out_next.status = skt_pkg::ST_DUPLICATE;
                    end
                    else
                    begin
                        out_next.status = skt_pkg::ST_INSERTED;
                        insert_en       = 1'b1;
                    end
                end
                else
                begin
                    if (tail_res.hit)
                    begin
                        out_next.status         = skt_pkg::ST_FOUND;
                        out_next.found_quantity = tail_res.qty;
                    end
                    else
                    begin
                        out_next.status = skt_pkg::ST_NOT_FOUND;
                    end
                end
            end
            default:
            begin
                state_next = skt_pkg::S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= skt_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the command on a transfer; register the result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= request;
        end
        out_reg <= out_next;
    end

    assign busy         = (state_reg != skt_pkg::S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

FILE: rtl/skt_checker.sv
// Port checker for the sorted key table, bound to the top level.
module skt_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              result_valid,
    input skt_pkg::skt_out_t result
);

    // A transfer starts the operation
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after request transfer");

    // Each result is a single-cycle strobe
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    // The end of an operation delivers its result
    a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid)
        else $error("operation ended without a result");

    // No result while an operation is in flight
    a_no_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !result_valid)
        else $error("result strobe while busy");

    // Quantity is zero unless a key was found
    a_qty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status != skt_pkg::ST_FOUND))
            |-> (result.found_quantity == 32'sd0))
        else $error("nonzero quantity without a found status");

endmodule

bind sorted_key_table_core skt_checker u_skt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

FILE: tb/sorted_key_table_core_test.sv
// Self-checking testbench for the sorted key table core.
`timescale 1ns / 100ps

module sorted_key_table_core_test;

    localparam int CAPACITY = 16;
    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    skt_pkg::skt_in_t   request;
    logic               result_valid;
    skt_pkg::skt_out_t  result;

    // Shadow copy of the table, in ascending key order
    logic signed [31:0] table_keys [CAPACITY];
    logic signed [31:0] table_qtys [CAPACITY];
    int                 table_fill;

    skt_pkg::skt_out_t expected_answers [$];
    int                mismatch_count;

    sorted_key_table_core #(
        .CAPACITY (CAPACITY)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Apply one operation to the shadow table and return the answer it gives
    function automatic skt_pkg::skt_out_t apply_op(skt_pkg::skt_in_t op);
        int                pos;
        int                i;
        bit                hit;
        skt_pkg::skt_out_t ans;
        pos = 0;
        while (pos < table_fill && table_keys[pos] < op.part_key)
            pos++;
        hit = (pos < table_fill) && (table_keys[pos] == op.part_key);
        ans.status         = skt_pkg::ST_NOT_FOUND;
        ans.found_quantity = '0;
        if (op.mode == skt_pkg::MODE_INSERT)
        begin
            // fullness wins over a duplicate key
            if (table_fill >= CAPACITY)
                ans.status = skt_pkg::ST_FULL;
            else if (hit)
                ans.status = skt_pkg::ST_DUPLICATE;
            else
            begin
                for (i = table_fill; i > pos; i--)
                begin
                    table_keys[i] = table_keys[i - 1];
                    table_qtys[i] = table_qtys[i - 1];
                end
                table_keys[pos] = op.part_key;
                table_qtys[pos] = op.quantity;
                table_fill++;
                ans.status = skt_pkg::ST_INSERTED;
            end
        end
        else if (hit)
        begin
            ans.status         = skt_pkg::ST_FOUND;
            ans.found_quantity = table_qtys[pos];
        end
        return ans;
    endfunction

    // Drive one operation, hold it until the core takes it, then record its answer
    task automatic send_op(input logic mode, input logic signed [31:0] key,
                           input logic signed [31:0] qty, input int idle_pct);
        skt_pkg::skt_in_t op;
        op.mode     = mode;
        op.part_key = key;
        op.quantity = qty;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
        request <= op;
        start   <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_answers.push_back(apply_op(op));
    endtask

    // Pick a key that often hits the table, lands right next to a stored key, or is an edge value
    function automatic logic signed [31:0] pick_key();
        int r;
        logic signed [31:0] k;
        r = $urandom_range(9);
        k = $urandom;
        if (table_fill > 0 && r < 4)
            k = table_keys[$urandom_range(table_fill - 1)];
        else if (table_fill > 0 && r == 4)
            k = table_keys[$urandom_range(table_fill - 1)] + ($urandom_range(1) ? 1 : -1);
        else if (r == 5)
        begin
            case ($urandom_range(3))
                0: k = KEY_MIN;
                1: k = KEY_MAX;
                2: k = '0;
                default: k = -1;
            endcase
        end
        return k;
    endfunction

    task automatic report_mismatch(input string what, input skt_pkg::skt_out_t want,
                                   input skt_pkg::skt_out_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%t: %s: expected status %0d qty %0d, got status %0d qty %0d",
                     $realtime, what, want.status, want.found_quantity,
                     got.status, got.found_quantity);
    endtask

    // Compare each result transfer with the oldest expected answer
    always @(posedge clk)
    begin : check_answers
        skt_pkg::skt_out_t want;
        if (rst_n && result_valid)
        begin
            if (expected_answers.size() == 0)
            begin
                want = '0;
                report_mismatch("unexpected result", want, result);
            end
            else
            begin
                want = expected_answers.pop_front();
                if (result.status !== want.status)
                    report_mismatch("status", want, result);
                else if (result.found_quantity !== want.found_quantity)
                    report_mismatch("found_quantity", want, result);
            end
        end
    end

    // Empty table, extreme keys and quantities, duplicate refusal, hits and misses
    task automatic test_directed();
        send_op(skt_pkg::MODE_LOOKUP, 32'sd7, 32'sd0, 0);
        send_op(skt_pkg::MODE_INSERT, KEY_MIN, KEY_MAX, 0);
        send_op(skt_pkg::MODE_INSERT, KEY_MAX, KEY_MIN, 0);
        send_op(skt_pkg::MODE_INSERT, 32'sd0, 32'sd0, 0);
        send_op(skt_pkg::MODE_INSERT, -32'sd1, -32'sd1, 0);
        send_op(skt_pkg::MODE_INSERT, KEY_MIN, 32'sd5, 0);
        send_op(skt_pkg::MODE_LOOKUP, KEY_MIN, -32'sd1, 0);
        send_op(skt_pkg::MODE_LOOKUP, KEY_MAX, 32'sd0, 0);
        send_op(skt_pkg::MODE_LOOKUP, 32'sd0, KEY_MAX, 0);
        send_op(skt_pkg::MODE_LOOKUP, -32'sd1, KEY_MIN, 0);
        send_op(skt_pkg::MODE_LOOKUP, 32'sd1, 32'sd0, 0);
        send_op(skt_pkg::MODE_INSERT, 32'sd1, 32'sh5555_5555, 0);
    endtask

    // Mixed random inserts and lookups
    task automatic test_random(input int count, input int idle_pct);
        int n;
        for (n = 0; n < count; n++)
            send_op(1'($urandom_range(1)), pick_key(), $urandom, idle_pct);
    endtask

    // Fill the table, insert with a stored key and with a new one, then look up the end keys
    task automatic test_full_table();
        while (table_fill < CAPACITY)
            send_op(skt_pkg::MODE_INSERT, $urandom, $urandom, 35);
        send_op(skt_pkg::MODE_INSERT, table_keys[$urandom_range(CAPACITY - 1)], $urandom, 0);
        send_op(skt_pkg::MODE_INSERT, table_keys[0] - 1, $urandom, 0);
        send_op(skt_pkg::MODE_LOOKUP, table_keys[0], 32'sd0, 0);
        send_op(skt_pkg::MODE_LOOKUP, table_keys[CAPACITY - 1], 32'sd0, 0);
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        start          <= 1'b0;
        request        <= '0;
        table_fill     = 0;
        mismatch_count = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random(550, 35);
        test_full_table();
        test_random(540, 67);
        test_random(540, 0);
        start <= 1'b0;

        // drain outstanding answers, then watch for strays
        while (expected_answers.size() != 0)
            @(posedge clk);
        repeat (CAPACITY + 4) @(posedge clk);
        if (mismatch_count == 0 && expected_answers.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: sorted_key_table_core.f
rtl/skt_pkg.sv
rtl/skt_cell.sv
rtl/sorted_key_table_core.sv
rtl/skt_checker.sv
tb/sorted_key_table_core_test.sv
